[src/segmented_memory_manager_assert.svh]
`ifndef SEGMENTED_MEMORY_MANAGER_ASSERT_SVH
`define SEGMENTED_MEMORY_MANAGER_ASSERT_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define SMM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante, outside reset.
`define SMM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/smm_pkg.sv]
package smm_pkg;

    // Field widths of the command and result beats
    localparam int SEG_W  = 6;
    localparam int OFF_W  = 8;
    localparam int LEN_W  = 9;
    localparam int WORD_W = 32;
    localparam int STAT_W = 3;

    typedef enum logic [1:0] {
        CMD_MAP   = 2'd0,
        CMD_UNMAP = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_STORE = 2'd3
    } cmd_e_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_FREE    = 3'd1,
        ST_UNMAPPED   = 3'd2,
        ST_BAD_OFFSET = 3'd3,
        ST_TOO_LONG   = 3'd4
    } status_e_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_ZERO,
        S_READ
    } state_e_t;

    typedef struct packed {
        cmd_e_t              command;
        logic [SEG_W-1:0]    segment;
        logic [OFF_W-1:0]    offset;
        logic [WORD_W-1:0]   value;
        logic [LEN_W-1:0]    length;
    } request_t;

    typedef struct packed {
        logic [WORD_W-1:0]   read_value;
        logic [SEG_W-1:0]    new_segment;
        logic [STAT_W-1:0]   status;
    } result_t;

    // One segment table entry
    typedef struct packed {
        logic                mapped;
        logic [LEN_W-1:0]    length;
    } seg_entry_t;

    // Free list controls from the sequencer
    typedef struct packed {
        logic init;
        logic pop;
        logic push;
    } fl_ctl_t;

endpackage

[src/smm_ram.sv]
module smm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/smm_free_list.sv]
`include "segmented_memory_manager_assert.svh"

module smm_free_list #(
    parameter int NUM_SEGMENTS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  smm_pkg::fl_ctl_t                ctl,
    input  logic [$clog2(NUM_SEGMENTS)-1:0] init_slot,
    input  logic [$clog2(NUM_SEGMENTS)-1:0] push_id,
    output logic [$clog2(NUM_SEGMENTS)-1:0] head_id,
    output logic                            empty,
    output logic                            full
);

    localparam int IDW   = $clog2(NUM_SEGMENTS);
    localparam int CNT_W = $clog2(NUM_SEGMENTS + 1);
    localparam logic [IDW-1:0]   LAST_SLOT = IDW'(NUM_SEGMENTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(NUM_SEGMENTS);

    logic [IDW-1:0]   head_reg, head_next;
    logic [IDW-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             q_we;
    logic [IDW-1:0]   q_waddr;
    logic [IDW-1:0]   q_wdata;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULL_CNT);

    // Advance head on pop, tail on push, wrapping at the last slot
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.pop)
        begin
            head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
            count_next = count_next - 1'b1;
        end
        if (ctl.push)
        begin
            tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
            count_next = count_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= FULL_CNT;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Fill with identifiers in order during the sweep, else append at tail
    assign q_we    = ctl.init | ctl.push;
    assign q_waddr = ctl.init ? init_slot : tail_reg;
    assign q_wdata = ctl.init ? init_slot : push_id;

    smm_ram #(
        .WIDTH (IDW),
        .DEPTH (NUM_SEGMENTS)
    ) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (1'b1),
        .raddr (head_reg),
        .rdata (head_id)
    );

    `SMM_ASSERT_IMP(a_no_pop_empty, ctl.pop, count_reg != '0, "pop from empty free list")
    `SMM_ASSERT_IMP(a_no_push_full, ctl.push, count_reg != FULL_CNT, "push to full free list")
    `SMM_ASSERT_IMP(a_init_alone, ctl.init, !ctl.pop && !ctl.push, "free list init overlaps")

endmodule

[src/segmented_memory_manager.sv]
// Segmented word memory: map, unmap, load and store, one command in flight.
// The done strobe follows the execute state for unmap, store, map of length
// zero and any error, the read state for load and the zeroing state for map.
// Throughput: next command accepted in the cycle done is shown; map zeroing
// writes one word per cycle. After reset busy is high while the table and
// free list are swept; results are never stalled.
`include "segmented_memory_manager_assert.svh"

module segmented_memory_manager #(
    parameter int NUM_SEGMENTS      = 64,
    parameter int MAX_SEGMENT_WORDS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  smm_pkg::request_t request,
    output logic              done,
    output smm_pkg::result_t  result
);

    localparam int IDW   = $clog2(NUM_SEGMENTS);
    localparam int WORDS = NUM_SEGMENTS * MAX_SEGMENT_WORDS;
    localparam int WAW   = $clog2(WORDS);
    localparam int SXW   = (IDW > smm_pkg::SEG_W) ? IDW : smm_pkg::SEG_W;
    localparam int TEW   = $bits(smm_pkg::seg_entry_t);
    localparam logic [IDW-1:0] LAST_SLOT = IDW'(NUM_SEGMENTS - 1);
    localparam logic [SXW:0]   NSEG_X    = (SXW + 1)'(NUM_SEGMENTS);
    localparam logic [WAW-1:0] SEG_STEP  = WAW'(MAX_SEGMENT_WORDS);

    smm_pkg::state_e_t  state_reg, state_next;
    smm_pkg::request_t  req_reg;
    smm_pkg::result_t   result_reg, result_next;
    smm_pkg::result_t   pend_reg, pend_next;
    logic               done_reg, done_next;
    logic [IDW-1:0]     clr_reg;
    logic [WAW-1:0]     waddr_reg, waddr_next;
    logic [smm_pkg::LEN_W-1:0] left_reg, left_next;

    logic               accept;
    logic [SXW-1:0]     in_seg_wide;
    logic [SXW-1:0]     req_seg_wide;
    logic [IDW-1:0]     req_seg_idx;
    logic [SXW-1:0]     id_wide;
    logic               seg_ok;
    logic               live;
    logic               off_bad;
    logic               len_bad;
    logic               len_zero;
    logic [WAW-1:0]     acc_addr;
    logic [WAW-1:0]     map_base;

    smm_pkg::seg_entry_t tbl_entry;
    smm_pkg::seg_entry_t tbl_wentry;
    logic [TEW-1:0]     tbl_rdata;
    logic               tbl_we;
    logic [IDW-1:0]     tbl_waddr;

    smm_pkg::fl_ctl_t   fl_ctl;
    logic [IDW-1:0]     fl_head_id;
    logic               fl_empty;
    logic               fl_full;

    logic               wm_we;
    logic [WAW-1:0]     wm_waddr;
    logic [smm_pkg::WORD_W-1:0] wm_wdata;
    logic               wm_re;
    logic [smm_pkg::WORD_W-1:0] wm_rdata;

    assign busy   = (state_reg != smm_pkg::S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    // Decode the held command against the table entry read at accept
    assign in_seg_wide  = SXW'(request.segment);
    assign req_seg_wide = SXW'(req_reg.segment);
    assign req_seg_idx  = req_seg_wide[IDW-1:0];
    assign id_wide      = SXW'(fl_head_id);
    assign seg_ok       = ({1'b0, req_seg_wide} < NSEG_X);
    assign tbl_entry    = smm_pkg::seg_entry_t'(tbl_rdata);
    assign live         = seg_ok && tbl_entry.mapped;
    assign off_bad      = (smm_pkg::LEN_W'(req_reg.offset) >= tbl_entry.length);
    assign len_bad      = (32'(req_reg.length) > 32'(MAX_SEGMENT_WORDS));
    assign len_zero     = (req_reg.length == '0);
    assign acc_addr     = WAW'(req_seg_idx) * SEG_STEP + WAW'(req_reg.offset);
    assign map_base     = WAW'(fl_head_id) * SEG_STEP;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smm_pkg::S_CLEAR:
            begin
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = smm_pkg::S_IDLE;
                end
            end
            smm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = smm_pkg::S_EXEC;
                end
            end
            smm_pkg::S_EXEC:
            begin
                state_next = smm_pkg::S_IDLE;
                if (req_reg.command == smm_pkg::CMD_MAP && !len_bad && !fl_empty && !len_zero)
                begin
                    state_next = smm_pkg::S_ZERO;
                end
                else if (req_reg.command == smm_pkg::CMD_LOAD && live && !off_bad)
                begin
                    state_next = smm_pkg::S_READ;
                end
            end
            smm_pkg::S_ZERO:
            begin
                if (left_reg == smm_pkg::LEN_W'(1))
                begin
                    state_next = smm_pkg::S_IDLE;
                end
            end
            smm_pkg::S_READ:
            begin
                state_next = smm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = smm_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs: memory controls, free list controls and the result beat
    always_comb
    begin
        fl_ctl      = '0;
        tbl_we      = 1'b0;
        tbl_waddr   = clr_reg;
        tbl_wentry  = '0;
        wm_we       = 1'b0;
        wm_waddr    = acc_addr;
        wm_wdata    = req_reg.value;
        wm_re       = 1'b0;
        done_next   = 1'b0;
        result_next = result_reg;
        pend_next   = pend_reg;
        waddr_next  = waddr_reg;
        left_next   = left_reg;
        unique case (state_reg)
            smm_pkg::S_CLEAR:
            begin
                fl_ctl.init = 1'b1;
                tbl_we      = 1'b1;
            end
            smm_pkg::S_IDLE:
            begin
            end
            smm_pkg::S_EXEC:
            begin
                result_next = '0;
                result_next.status = smm_pkg::ST_OK;
                done_next = 1'b1;
                case (req_reg.command) inside
                    smm_pkg::CMD_MAP:
                    begin
                        if (len_bad)
                        begin
                            result_next.status = smm_pkg::ST_TOO_LONG;
                        end
                        else if (fl_empty)
                        begin
                            result_next.status = smm_pkg::ST_NO_FREE;
                        end
                        else
                        begin
                            // Take the oldest free id, record it, start zeroing unless length is zero
                            fl_ctl.pop = 1'b1;
                            tbl_we     = 1'b1;
                            tbl_waddr  = fl_head_id;
                            tbl_wentry.mapped = 1'b1;
                            tbl_wentry.length = req_reg.length;
                            result_next.new_segment = id_wide[smm_pkg::SEG_W-1:0];
                            pend_next  = result_next;
                            waddr_next = map_base;
                            left_next  = req_reg.length;
                            done_next  = len_zero;
                        end
                    end
                    smm_pkg::CMD_UNMAP:
                    begin
                        if (!live)
                        begin
                            result_next.status = smm_pkg::ST_UNMAPPED;
                        end
                        else
                        begin
                            // Drop the entry and append the id to the free list unless it is full
                            tbl_we      = 1'b1;
                            tbl_waddr   = req_seg_idx;
                            fl_ctl.push = !fl_full;
                        end
                    end
                    smm_pkg::CMD_LOAD, smm_pkg::CMD_STORE:
                    begin
                        if (!live)
                        begin
                            result_next.status = smm_pkg::ST_UNMAPPED;
                        end
                        else if (off_bad)
                        begin
                            result_next.status = smm_pkg::ST_BAD_OFFSET;
                        end
                        else if (req_reg.command == smm_pkg::CMD_STORE)
                        begin
                            wm_we = 1'b1;
                        end
                        else
                        begin
                            wm_re     = 1'b1;
                            done_next = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            smm_pkg::S_ZERO:
            begin
                // Clear one word per cycle and count down
                wm_we      = 1'b1;
                wm_waddr   = waddr_reg;
                wm_wdata   = '0;
                waddr_next = waddr_reg + 1'b1;
                left_next  = left_reg - 1'b1;
                if (left_reg == smm_pkg::LEN_W'(1))
                begin
                    done_next   = 1'b1;
                    result_next = pend_reg;
                end
            end
            smm_pkg::S_READ:
            begin
                done_next   = 1'b1;
                result_next = '0;
                result_next.read_value = wm_rdata;
                result_next.status     = smm_pkg::ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smm_pkg::S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (state_reg == smm_pkg::S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        result_reg <= result_next;
        pend_reg   <= pend_next;
        waddr_reg  <= waddr_next;
        left_reg   <= left_next;
    end

    // Segment table: mapped flag and length, read at the accepted segment
    smm_ram #(
        .WIDTH (TEW),
        .DEPTH (NUM_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (TEW'(tbl_wentry)),
        .re    (1'b1),
        .raddr (in_seg_wide[IDW-1:0]),
        .rdata (tbl_rdata)
    );

    // Segment word storage
    smm_ram #(
        .WIDTH (smm_pkg::WORD_W),
        .DEPTH (WORDS)
    ) u_words (
        .clk   (clk),
        .we    (wm_we),
        .waddr (wm_waddr),
        .wdata (wm_wdata),
        .re    (wm_re),
        .raddr (acc_addr),
        .rdata (wm_rdata)
    );

    smm_free_list #(
        .NUM_SEGMENTS (NUM_SEGMENTS)
    ) u_free_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (fl_ctl),
        .init_slot (clr_reg),
        .push_id   (req_seg_idx),
        .head_id   (fl_head_id),
        .empty     (fl_empty),
        .full      (fl_full)
    );

    `SMM_ASSERT_NEXT(a_done_single, done, !done, "result strobe held two cycles")
    `SMM_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted beat did not raise busy")
    `SMM_ASSERT_IMP(a_zero_left, state_reg == smm_pkg::S_ZERO, left_reg != '0, "zeroing with no words left")

endmodule
